// ===== hw/rtl/irm_pkg.sv =====
// Shared types and constants for the interval range map.
package irm_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 8;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_ASSIGN = 1'b1
  } irm_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } irm_status_t;

  typedef struct packed {
    irm_op_t            op;
    logic [KEY_W-1:0]   key_begin;
    logic [KEY_W-1:0]   key_end;
    logic [VAL_W-1:0]   new_value;
    logic [KEY_W-1:0]   lookup_key;
  } irm_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   found_value;
    irm_status_t        status;
  } irm_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } irm_entry_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CHECK,
    S_MV_RD,
    S_MV_WR,
    S_WR_LO,
    S_WR_HI
  } irm_state_t;

endpackage

// ===== hw/rtl/irm_table.sv =====
// Breakpoint table memory: one write port, one registered read port.
module irm_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  irm_pkg::irm_entry_t wr_entry,
  input  logic [AW-1:0]       rd_addr,
  output irm_pkg::irm_entry_t rd_entry
);
  import irm_pkg::*;

  irm_entry_t mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/interval_range_map.sv =====
// Top level of the interval range map: sequencer around the breakpoint table.
//
// Usage: an item transfers on in_data when start is high and busy is low.
// A lookup returns the value of the last breakpoint at or below lookup_key;
// an assign writes new_value over [key_begin, key_end) and reports done,
// empty interval or table full. Each item gives one result on out_data,
// marked by a one-cycle out_valid pulse; the receiver cannot stall it.
// The table sits in one memory with a registered read, so the scan
// reads and then compares each breakpoint visited; a lookup visits at
// most the entry count. An assign then reads and writes each moved tail
// entry and writes the new pair. An empty interval answers in the cycle
// after its transfer.
// cfg_data writes initial_value while the block is idle and start is low
// (cfg_ready high) and resets the table to the single breakpoint
// (0, initial_value).
// After reset the block writes entry zero, then idles.
module interval_range_map #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  irm_pkg::irm_in_t              in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [irm_pkg::VAL_W-1:0]     cfg_data,
  output logic                          out_valid,
  output irm_pkg::irm_out_t             out_data
);
  import irm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = CW + 1;

  irm_state_t       state_r, state_nxt;
  irm_in_t          item_r, item_nxt;
  logic [VAL_W-1:0] init_val_r, init_val_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic             lo_found_r, lo_found_nxt;
  logic [VAL_W-1:0] last_val_r, last_val_nxt;
  logic [CW-1:0]    newcnt_r, newcnt_nxt;
  logic [CW-1:0]    src_r, src_nxt;
  logic [CW-1:0]    dst_r, dst_nxt;
  logic             desc_r, desc_nxt;
  logic             out_valid_r, out_valid_nxt;
  irm_out_t         out_r, out_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  irm_entry_t       wr_entry;
  logic [AW-1:0]    rd_addr;
  irm_entry_t       rd_entry;

  logic [KEY_W-1:0] limit;
  logic             key_le;
  logic [NW-1:0]    newcnt_wide;
  logic [NW-1:0]    lo_plus2;
  logic             cfg_xfer;
  logic             in_xfer;

  irm_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // hold off the config write while an item is offered
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // scan compare and assign sizing
  assign limit       = (item_r.op == OP_ASSIGN) ? item_r.key_end : item_r.lookup_key;
  assign key_le      = (rd_entry.key <= limit);
  assign newcnt_wide = NW'(count_r) - NW'(hi_r) + NW'(lo_r) + NW'(2);
  assign lo_plus2    = NW'(lo_r) + NW'(2);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    init_val_nxt  = init_val_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lo_found_nxt  = lo_found_r;
    last_val_nxt  = last_val_r;
    newcnt_nxt    = newcnt_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    desc_nxt      = desc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      S_INIT: begin
        count_nxt = CW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_xfer) begin
          init_val_nxt = cfg_data;
          count_nxt    = CW'(1);
        end else if (in_xfer) begin
          item_nxt     = in_data;
          idx_nxt      = '0;
          lo_nxt       = count_r;
          hi_nxt       = count_r;
          lo_found_nxt = 1'b0;
          if (in_data.op == OP_ASSIGN && !(in_data.key_begin < in_data.key_end)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{found_value: '0, status: ST_EMPTY};
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (key_le) begin
          last_val_nxt = rd_entry.value;
        end
        if (!lo_found_r && rd_entry.key >= item_r.key_begin) begin
          lo_nxt       = idx_r;
          lo_found_nxt = 1'b1;
        end
        if (!key_le) begin
          hi_nxt    = idx_r;
          state_nxt = S_CHECK;
        end else if (idx_r + CW'(1) == count_r) begin
          state_nxt = S_CHECK;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_CHECK: begin
        if (item_r.op == OP_LOOKUP) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found_value: last_val_r, status: ST_DONE};
          state_nxt     = S_IDLE;
        end else if (newcnt_wide > NW'(DEPTH)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found_value: '0, status: ST_FULL};
          state_nxt     = S_IDLE;
        end else begin
          newcnt_nxt = CW'(newcnt_wide);
          if (hi_r < count_r && lo_plus2 > NW'(hi_r)) begin
            desc_nxt  = 1'b1;
            src_nxt   = count_r - CW'(1);
            dst_nxt   = CW'(newcnt_wide - NW'(1));
            state_nxt = S_MV_RD;
          end else if (hi_r < count_r && lo_plus2 < NW'(hi_r)) begin
            desc_nxt  = 1'b0;
            src_nxt   = hi_r;
            dst_nxt   = CW'(lo_plus2);
            state_nxt = S_MV_RD;
          end else begin
            state_nxt = S_WR_LO;
          end
        end
      end
      S_MV_RD: begin
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        if (desc_r) begin
          if (src_r == hi_r) begin
            state_nxt = S_WR_LO;
          end else begin
            src_nxt   = src_r - CW'(1);
            dst_nxt   = dst_r - CW'(1);
            state_nxt = S_MV_RD;
          end
        end else begin
          if (src_r + CW'(1) == count_r) begin
            state_nxt = S_WR_LO;
          end else begin
            src_nxt   = src_r + CW'(1);
            dst_nxt   = dst_r + CW'(1);
            state_nxt = S_MV_RD;
          end
        end
      end
      S_WR_LO: begin
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        count_nxt     = newcnt_r;
        out_valid_nxt = 1'b1;
        out_nxt       = '{found_value: '0, status: ST_DONE};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // memory port control
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_entry = '{key: '0, value: init_val_r};
    rd_addr  = '0;
    case (state_r)
      S_INIT: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (cfg_xfer) begin
          wr_en    = 1'b1;
          wr_entry = '{key: '0, value: cfg_data};
        end
      end
      S_SCAN_RD: begin
        rd_addr = idx_r[AW-1:0];
      end
      S_MV_RD: begin
        rd_addr = src_r[AW-1:0];
      end
      S_MV_WR: begin
        wr_en    = 1'b1;
        wr_addr  = dst_r[AW-1:0];
        wr_entry = rd_entry;
      end
      S_WR_LO: begin
        wr_en    = 1'b1;
        wr_addr  = lo_r[AW-1:0];
        wr_entry = '{key: item_r.key_begin, value: item_r.new_value};
      end
      S_WR_HI: begin
        wr_en    = 1'b1;
        wr_addr  = AW'(lo_plus2 - NW'(1));
        wr_entry = '{key: item_r.key_end, value: last_val_r};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_val_r  <= '0;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_val_r  <= init_val_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lo_found_r <= lo_found_nxt;
    last_val_r <= last_val_nxt;
    newcnt_r   <= newcnt_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    desc_r     <= desc_nxt;
    out_r      <= out_nxt;
  end

endmodule
